[rtl/layered_rect_coordinate_accumulator_macros.svh]
// ----------------------------------------------------------------------------
// layered rect coordinate accumulator assertion macros
// shared concurrent assertion forms, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LAYERED_RECT_COORDINATE_ACCUMULATOR_MACROS_SVH
`define LAYERED_RECT_COORDINATE_ACCUMULATOR_MACROS_SVH

// condition and consequence in the same cycle
`define LRCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define LRCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lrca_pkg.sv]
// ----------------------------------------------------------------------------
// lrca_pkg
// widths, codes and queue entry types of the rect coordinate accumulator
// ----------------------------------------------------------------------------
package lrca_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int TYPE_W    = 4;
  localparam int REG_IDX_W = 3;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_W;
  localparam int SUM_W     = TERM_W + 2;

  localparam int LRCA_Q_DEPTH   = 2;
  localparam int LRCA_OUT_DEPTH = 2;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t SCALE_ONE = q_t'(1 << FRAC_W);

  typedef enum logic [TYPE_W-1:0] {
    CT_DESKTOP     = 4'd0,
    CT_PARENT_BASE = 4'd1,
    CT_PARENT      = 4'd2,
    CT_PARENT_X    = 4'd3,
    CT_PARENT_Y    = 4'd4,
    CT_SCREEN_BASE = 4'd5,
    CT_SCREEN      = 4'd6,
    CT_SCREEN_X    = 4'd7,
    CT_SCREEN_Y    = 4'd8
  } coord_type_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PARENT_X = 3'd0,
    REG_PARENT_Y = 3'd1,
    REG_PARENT_W = 3'd2,
    REG_PARENT_H = 3'd3,
    REG_SCREEN_X = 3'd4,
    REG_SCREEN_Y = 3'd5,
    REG_SCREEN_W = 3'd6,
    REG_SCREEN_H = 3'd7
  } reg_idx_t;

  // classified group, front to back
  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   w;
    q_t   h;
    q_t   scale_a;   // x and w
    q_t   scale_b;   // y and h
    q_t   org_x;
    q_t   org_y;
    logic scaled;
    logic add;
    logic err;
    logic first;
    logic last;
  } job_t;

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   w;
    q_t   h;
    logic err;
  } res_t;

endpackage

[rtl/lrca_fifo.sv]
// ----------------------------------------------------------------------------
// lrca_fifo
// small flop queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module lrca_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/lrca_front.sv]
// ----------------------------------------------------------------------------
// lrca_front
// configuration registers and type decode of incoming coordinate groups
// ----------------------------------------------------------------------------
module lrca_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lrca_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [lrca_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [lrca_pkg::TYPE_W-1:0]       in_coord_type,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_x,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_y,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_w,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_h,
  input  logic                              in_parent_present,
  input  logic                              in_first_group,
  input  logic                              in_last_group,
  output logic                              job_push,
  input  logic                              job_full,
  output lrca_pkg::job_t                    job
);

  import lrca_pkg::*;

  q_t parent_x_r, parent_y_r, parent_w_r, parent_h_r;
  q_t screen_x_r, screen_y_r, screen_w_r, screen_h_r;
  logic is_parent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parent_x_r <= '0;
      parent_y_r <= '0;
      parent_w_r <= '0;
      parent_h_r <= '0;
      screen_x_r <= '0;
      screen_y_r <= '0;
      screen_w_r <= SCALE_ONE;
      screen_h_r <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PARENT_X: parent_x_r <= cfg_wdata;
        REG_PARENT_Y: parent_y_r <= cfg_wdata;
        REG_PARENT_W: parent_w_r <= cfg_wdata;
        REG_PARENT_H: parent_h_r <= cfg_wdata;
        REG_SCREEN_X: screen_x_r <= cfg_wdata;
        REG_SCREEN_Y: screen_y_r <= cfg_wdata;
        REG_SCREEN_W: screen_w_r <= cfg_wdata;
        REG_SCREEN_H: screen_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full  = job_full;
  assign job_push = in_push && !job_full;

  assign is_parent = (in_coord_type == CT_PARENT_BASE) || (in_coord_type == CT_PARENT)
                  || (in_coord_type == CT_PARENT_X) || (in_coord_type == CT_PARENT_Y);

  always_comb begin
    job.x       = in_coord_x;
    job.y       = in_coord_y;
    job.w       = in_coord_w;
    job.h       = in_coord_h;
    job.scale_a = '0;
    job.scale_b = '0;
    job.org_x   = '0;
    job.org_y   = '0;
    job.scaled  = 1'b1;
    job.add     = 1'b1;
    job.err     = 1'b0;
    job.first   = in_first_group;
    job.last    = in_last_group;
    if (is_parent && !in_parent_present) begin
      job.add = 1'b0;
      job.err = 1'b1;
    end else begin
      unique case (coord_type_t'(in_coord_type))
        CT_DESKTOP: job.scaled = 1'b0;
        CT_PARENT_BASE: begin
          job.scale_a = parent_w_r;
          job.scale_b = parent_h_r;
          job.org_x   = parent_x_r;
          job.org_y   = parent_y_r;
        end
        CT_PARENT: begin
          job.scale_a = parent_w_r;
          job.scale_b = parent_h_r;
        end
        CT_PARENT_X: begin
          job.scale_a = parent_w_r;
          job.scale_b = parent_w_r;
        end
        CT_PARENT_Y: begin
          job.scale_a = parent_h_r;
          job.scale_b = parent_h_r;
        end
        CT_SCREEN_BASE: begin
          job.scale_a = screen_w_r;
          job.scale_b = screen_h_r;
          job.org_x   = screen_x_r;
          job.org_y   = screen_y_r;
        end
        CT_SCREEN: begin
          job.scale_a = screen_w_r;
          job.scale_b = screen_h_r;
        end
        CT_SCREEN_X: begin
          job.scale_a = screen_w_r;
          job.scale_b = screen_w_r;
        end
        CT_SCREEN_Y: begin
          job.scale_a = screen_h_r;
          job.scale_b = screen_h_r;
        end
        default: begin
          job.add = 1'b0;
          job.err = 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/lrca_back.sv]
// ----------------------------------------------------------------------------
// lrca_back
// scale multiply stage followed by the saturating accumulate stage
// ----------------------------------------------------------------------------
module lrca_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_empty,
  output logic             job_pop,
  input  lrca_pkg::job_t   job,
  input  logic             res_full,
  output logic             res_push,
  output lrca_pkg::res_t   res
);

  import lrca_pkg::*;

  function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] top;
    top = v[SUM_W-1:DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  logic                     stall, fire;
  q_t                       coord [4];
  q_t                       scale [4];
  logic signed [PROD_W-1:0] prod  [4];
  logic signed [TERM_W-1:0] term_nxt [4];

  logic                     s1_vld_r;
  logic signed [TERM_W-1:0] s1_term_r [4];
  q_t                       s1_org_x_r, s1_org_y_r;
  logic                     s1_add_r, s1_err_r, s1_first_r, s1_last_r;

  q_t                       acc_r   [4];
  q_t                       acc_nxt [4];
  q_t                       base    [4];
  q_t                       org     [4];
  logic signed [SUM_W-1:0]  sum     [4];
  logic                     err_r, err_nxt;

  // a full result queue holds the whole back end
  assign stall   = res_full;
  assign job_pop = !job_empty && !stall;
  assign fire    = s1_vld_r && !stall;

  // multiply stage, one lane per component
  always_comb begin
    coord[0] = job.x;
    coord[1] = job.y;
    coord[2] = job.w;
    coord[3] = job.h;
    scale[0] = job.scale_a;
    scale[1] = job.scale_b;
    scale[2] = job.scale_a;
    scale[3] = job.scale_b;
    for (int i = 0; i < 4; i++) begin
      prod[i]     = PROD_W'(coord[i]) * PROD_W'(scale[i]);
      term_nxt[i] = job.scaled ? prod[i][PROD_W-1:FRAC_W] : TERM_W'(coord[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!stall) begin
      s1_vld_r <= !job_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      for (int i = 0; i < 4; i++) begin
        s1_term_r[i] <= term_nxt[i];
      end
      s1_org_x_r <= job.org_x;
      s1_org_y_r <= job.org_y;
      s1_add_r   <= job.add;
      s1_err_r   <= job.err;
      s1_first_r <= job.first;
      s1_last_r  <= job.last;
    end
  end

  // accumulate stage
  always_comb begin
    org[0] = s1_org_x_r;
    org[1] = s1_org_y_r;
    org[2] = '0;
    org[3] = '0;
    for (int i = 0; i < 4; i++) begin
      base[i]    = s1_first_r ? '0 : acc_r[i];
      sum[i]     = SUM_W'(base[i]) + SUM_W'(org[i]) + SUM_W'(s1_term_r[i]);
      acc_nxt[i] = s1_add_r ? sat_q(sum[i]) : base[i];
    end
    err_nxt = (s1_first_r ? 1'b0 : err_r) | s1_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
      err_r <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      err_r <= err_nxt;
    end
  end

  assign res_push = fire && s1_last_r;
  assign res.x    = acc_nxt[0];
  assign res.y    = acc_nxt[1];
  assign res.w    = acc_nxt[2];
  assign res.h    = acc_nxt[3];
  assign res.err  = err_nxt;

endmodule

[rtl/layered_rect_coordinate_accumulator.sv]
// path: an accepted last group crosses the job queue, s1 registers and result queue to out_*
// throughput: one group per cycle while out_full is low, held by the accumulate and saturate loop
// a full result queue stalls the back end; the job queue then fills and raises in_full
// reset: synchronous rst_n low empties both queues, zeroes sums and the error flag,
// sets parent registers to zero, screen origin to zero and screen scales to 1.0
// ----------------------------------------------------------------------------
// layered_rect_coordinate_accumulator
// scales and sums Q16.16 coordinate groups into one saturated rectangle
// ----------------------------------------------------------------------------
`include "layered_rect_coordinate_accumulator_macros.svh"

module layered_rect_coordinate_accumulator #(
  parameter int QUEUE_DEPTH = lrca_pkg::LRCA_Q_DEPTH,
  parameter int OUT_DEPTH   = lrca_pkg::LRCA_OUT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [lrca_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [lrca_pkg::DATA_W-1:0]        cfg_wdata,
  // group input
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [lrca_pkg::TYPE_W-1:0]        in_coord_type,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_x,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_y,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_w,
  input  logic signed [lrca_pkg::DATA_W-1:0] in_coord_h,
  input  logic                               in_parent_present,
  input  logic                               in_first_group,
  input  logic                               in_last_group,
  // rectangle output
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [lrca_pkg::DATA_W-1:0] out_result_x,
  output logic signed [lrca_pkg::DATA_W-1:0] out_result_y,
  output logic signed [lrca_pkg::DATA_W-1:0] out_result_w,
  output logic signed [lrca_pkg::DATA_W-1:0] out_result_h,
  output logic                               out_type_error
);

  import lrca_pkg::*;

  // front to back job transfer
  job_t job_in, job_out;
  logic mid_push, mid_full, mid_pop, mid_empty;

  // back to output queue result transfer
  res_t res_in, res_out;
  logic res_push, out_full;

  // front: config registers, type decode, item acceptance
  lrca_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_coord_type    (in_coord_type),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_w       (in_coord_w),
    .in_coord_h       (in_coord_h),
    .in_parent_present(in_parent_present),
    .in_first_group   (in_first_group),
    .in_last_group    (in_last_group),
    .job_push         (mid_push),
    .job_full         (mid_full),
    .job              (job_in)
  );

  // decoupling queue, lets front and back stall independently
  lrca_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .din  (job_in),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (job_out),
    .empty(mid_empty)
  );

  // back: multiply stage then accumulate stage
  lrca_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(mid_empty),
    .job_pop  (mid_pop),
    .job      (job_out),
    .res_full (out_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // result queue, keeps the back running while a result waits
  lrca_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_in),
    .full (out_full),
    .pop  (out_pop),
    .dout (res_out),
    .empty(out_empty)
  );

  assign out_result_x   = res_out.x;
  assign out_result_y   = res_out.y;
  assign out_result_w   = res_out.w;
  assign out_result_h   = res_out.h;
  assign out_type_error = res_out.err;

  // an accepted group is waiting in the job queue on the next cycle
  `LRCA_ASSERT_NEXT(a_accept_queued, in_push && !in_full, !mid_empty, "accepted group lost")
  // the back only takes a job when it can move and one is there
  `LRCA_ASSERT_NOW(a_pop_legal, mid_pop, !out_full && !mid_empty, "job taken while stalled")
  // an emitted rectangle is visible on the output side next cycle
  `LRCA_ASSERT_NEXT(a_result_lands, res_push, !out_empty, "result transfer dropped")

endmodule
